FILE: rtl/fmaa_pkg.sv
// Shared constants for the force-moment-about-axis pipeline.
// No dependencies; fmaa_mul and the top level refer to this package by scoped name.
package fmaa_pkg;

  // Field widths fixed by the stream format
  localparam int IN_W    = 32;
  localparam int N_IN    = 12;
  localparam int EPS_W   = 16;
  localparam int MOM_W   = 64;
  localparam int DST_W   = 32;

  // Operand slice width of the partial-product multipliers
  localparam int CHUNK_W = 32;

  // Saturation limits of the moment field
  localparam logic [MOM_W-1:0] MOM_MAX = {1'b0, {(MOM_W-1){1'b1}}};
  localparam logic [MOM_W-1:0] MOM_MIN = {1'b1, {(MOM_W-1){1'b0}}};

endpackage

FILE: rtl/fmaa_dly.sv
// Stall-aware delay line used to align operands between pipeline branches.
// Depends on nothing; the enable is the pipeline-wide advance signal.
module fmaa_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [D];

  // Shift on advance, hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int i = 1; i < D; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign dout = sr[D-1];

endmodule

FILE: rtl/fmaa_mul.sv
// Pipelined unsigned multiplier: one 32x32 partial product accumulated per stage.
// Depends on fmaa_pkg for the slice width.
module fmaa_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic [WA+WB-1:0] p
);

  localparam int CW  = fmaa_pkg::CHUNK_W;
  localparam int NA  = (WA + CW - 1) / CW;
  localparam int NB  = (WB + CW - 1) / CW;
  localparam int L   = NA * NB;
  localparam int WAP = NA * CW;
  localparam int WBP = NB * CW;
  localparam int WX  = WAP + WBP;

  logic [WAP-1:0] a_q   [L+1];
  logic [WBP-1:0] b_q   [L+1];
  logic [WX-1:0]  acc_q [L+1];

  assign a_q[0]   = WAP'(a);
  assign b_q[0]   = WBP'(b);
  assign acc_q[0] = '0;

  for (genvar k = 0; k < L; k++) begin : g_stg
    localparam int I = k / NB;
    localparam int J = k % NB;
    logic [2*CW-1:0] pp;

    assign pp = a_q[k][I*CW +: CW] * b_q[k][J*CW +: CW];

    // Add one shifted partial product, carry operands along
    always_ff @(posedge clk) begin
      if (en) begin
        a_q[k+1]   <= a_q[k];
        b_q[k+1]   <= b_q[k];
        acc_q[k+1] <= acc_q[k] + (WX'(pp) << (CW * (I + J)));
      end
    end
  end

  assign p = acc_q[L][WA+WB-1:0];

endmodule

FILE: rtl/fmaa_sqrt.sv
// Pipelined integer square root, one root bit resolved per stage (floor result).
// Depends on nothing; WN must be even, and the root takes WN/2 stages.
module fmaa_sqrt #(
  parameter int WN = 66
) (
  input  logic              clk,
  input  logic              en,
  input  logic [WN-1:0]     n,
  output logic [WN/2-1:0]   root
);

  localparam int WR = WN / 2;
  localparam int RW = WR + 3;

  logic [WN-1:0] n_q   [WR+1];
  logic [RW-1:0] rem_q [WR+1];
  logic [WR-1:0] rt_q  [WR+1];

  assign n_q[0]   = n;
  assign rem_q[0] = '0;
  assign rt_q[0]  = '0;

  for (genvar k = 0; k < WR; k++) begin : g_stg
    logic [RW-1:0] r2;
    logic [RW-1:0] trial;
    logic          ge;

    assign r2    = {rem_q[k][RW-3:0], n_q[k][WN-1 -: 2]};
    assign trial = {1'b0, rt_q[k], 2'b01};
    assign ge    = (r2 >= trial);

    // Try the next root bit, keep the remainder
    always_ff @(posedge clk) begin
      if (en) begin
        n_q[k+1]   <= n_q[k] << 2;
        rem_q[k+1] <= ge ? (r2 - trial) : r2;
        rt_q[k+1]  <= {rt_q[k][WR-2:0], ge};
      end
    end
  end

  assign root = rt_q[WR];

endmodule

FILE: rtl/fmaa_div.sv
// Pipelined restoring divider giving the low WQ quotient bits, one bit per stage,
// plus a flag for a quotient of 2^WQ or more. Depends on nothing.
module fmaa_div #(
  parameter int WN = 66,
  parameter int WD = 34,
  parameter int WQ = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WN-1:0] n,
  input  logic [WD-1:0] d,
  output logic [WQ-1:0] q,
  output logic          ovf
);

  localparam int WH = WN - WQ;
  localparam int WM = (WH > WD) ? WH : WD;

  logic [WH-1:0] hi;
  logic [WD-1:0] rem_q [WQ+1];
  logic [WD-1:0] d_q   [WQ+1];
  logic [WQ-1:0] ln_q  [WQ+1];
  logic [WQ-1:0] q_q   [WQ+1];
  logic          ov_q  [WQ+1];

  // High part at or above the divisor means the quotient does not fit
  assign hi       = n[WN-1:WQ];
  assign ov_q[0]  = (WM'(hi) >= WM'(d));
  assign rem_q[0] = WD'(hi);
  assign d_q[0]   = d;
  assign ln_q[0]  = n[WQ-1:0];
  assign q_q[0]   = '0;

  for (genvar k = 0; k < WQ; k++) begin : g_stg
    logic [WD:0] r2;
    logic        ge;

    assign r2 = {rem_q[k], ln_q[k][WQ-1]};
    assign ge = (r2 >= {1'b0, d_q[k]});

    // Bring down one dividend bit, subtract where it fits
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= WD'(ge ? (r2 - {1'b0, d_q[k]}) : r2);
        d_q[k+1]   <= d_q[k];
        ln_q[k+1]  <= ln_q[k] << 1;
        q_q[k+1]   <= {q_q[k][WQ-2:0], ge};
        ov_q[k+1]  <= ov_q[k];
      end
    end
  end

  assign q   = q_q[WQ];
  assign ovf = ov_q[WQ];

endmodule

FILE: rtl/force_moment_about_axis.sv
// Top level of the force-moment-about-axis pipeline.
// Depends on fmaa_pkg, fmaa_dly, fmaa_mul, fmaa_sqrt and fmaa_div.
//
// Usage:
//   s_* is the item stream: point, first and second axis point and force,
//   twelve signed fixed-point words. m_* returns moment and distance.
//   cfg_wr_en / cfg_wr_data write epsilon; write it only while idle.
// Throughput: one item per cycle while the receiver keeps m_tready high.
//   Every step (partial-product multipliers, bit-per-stage square roots and
//   dividers) is a separate register stage.
// Depth: the deepest path runs through the 132-bit square root (66 stages),
//   the 64-bit moment quotient (64 stages) and the last multiply's 12 partial products.
// Stall: the whole pipeline advances together. When the receiver holds off,
//   one more result lands in a skid register and only then s_tready drops,
//   so a waiting result never blocks the next transfer for that cycle and
//   nothing is lost or repeated.
// Reset: valid bits and the output side clear, epsilon returns to 1.
module force_moment_about_axis #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // pt_x, pt_y, pt_z, axis_a_x..z, axis_b_x..z, force_x..z, 32 bits each
  input  logic [fmaa_pkg::N_IN*fmaa_pkg::IN_W-1:0] s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // moment [63:0], distance [95:64]
  output logic [fmaa_pkg::MOM_W+fmaa_pkg::DST_W-1:0] m_tdata,
  input  logic                                     cfg_wr_en,
  input  logic [fmaa_pkg::EPS_W-1:0]               cfg_wr_data
);

  localparam int IW     = fmaa_pkg::IN_W;
  localparam int EW     = fmaa_pkg::EPS_W;
  localparam int CW     = fmaa_pkg::CHUNK_W;
  localparam int OW     = fmaa_pkg::MOM_W + fmaa_pkg::DST_W;
  localparam int DA_W   = IW + 1;
  localparam int PR_W   = 2 * DA_W;
  localparam int C_W    = PR_W + 1;
  localparam int CM_W   = PR_W;
  localparam int AS_W   = PR_W;
  localparam int CS_W   = 2 * CM_W;
  localparam int FC_W   = IW + CM_W;
  localparam int P_W    = FC_W + 2;
  localparam int PM_W   = P_W - 1;
  localparam int NC_W   = CS_W / 2;
  localparam int NA_W   = AS_W / 2;
  localparam int DEN1_W = NA_W + 1;
  localparam int SH_W   = EW + FRAC_BITS;
  localparam int NCE_W  = ((NC_W > SH_W) ? NC_W : SH_W) + 1;
  localparam int MN_W   = NC_W + PM_W;
  localparam int MD_W   = DEN1_W + NCE_W;
  localparam int MW     = fmaa_pkg::MOM_W;
  localparam int DW     = fmaa_pkg::DST_W;

  // Stage counts of each unit
  localparam int L_M1  = ((DA_W + CW - 1) / CW) * ((DA_W + CW - 1) / CW);
  localparam int L_CC  = ((CM_W + CW - 1) / CW) * ((CM_W + CW - 1) / CW);
  localparam int L_FC  = ((IW + CW - 1) / CW) * ((CM_W + CW - 1) / CW);
  localparam int L_SQC = CS_W / 2;
  localparam int L_SQA = AS_W / 2;
  localparam int L_MN  = ((NC_W + CW - 1) / CW) * ((PM_W + CW - 1) / CW);
  localparam int L_MD  = ((DEN1_W + CW - 1) / CW) * ((NCE_W + CW - 1) / CW);
  localparam int L_DM  = MW;
  localparam int L_DD  = DW;
  localparam int L_TOT = 1 + L_M1 + 2 + L_CC + 1 + L_SQC + 1 + L_MN + L_DM;

  // Alignment delays between branches
  localparam int D_F   = L_M1 + 2;
  localparam int D_FC  = L_CC - L_FC;
  localparam int D_NA  = 2 + L_CC + L_SQC - L_SQA;
  localparam int D_MD  = L_MN - L_MD;
  localparam int D_FLG = L_MN + L_DM;
  localparam int D_DST = L_MN + L_DM - L_DD;

  logic            en;
  logic [EW-1:0]   epsilon;
  logic            vld [L_TOT];

  logic            skid_v;
  logic [OW-1:0]   skid_d;
  logic            out_v;
  logic [OW-1:0]   out_d;

  // Advance whenever the skid register is free
  assign en       = !skid_v;
  assign s_tready = en;

  // Epsilon register
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EW'(1);
    end else if (cfg_wr_en) begin
      epsilon <= cfg_wr_data;
    end
  end

  // Valid chain beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L_TOT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < L_TOT; i++) vld[i] <= vld[i-1];
    end
  end

  // Stage 1: axis and lever vectors, magnitudes and product signs
  logic signed [DA_W-1:0] av [3];
  logic signed [DA_W-1:0] dv [3];
  logic [DA_W-1:0] am_n [3];
  logic [DA_W-1:0] dm_n [3];
  logic [IW-1:0]   fm_n [3];
  logic            fs_n [3];
  logic [DA_W-1:0] am [3];
  logic [DA_W-1:0] dm [3];
  logic [2:0]      ps1, ps2, ps1_n, ps2_n;
  logic [3*IW-1:0] f_m1;
  logic [2:0]      f_s1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      av[i] = DA_W'($signed(s_tdata[IW*(6+i) +: IW]))
            - DA_W'($signed(s_tdata[IW*(3+i) +: IW]));
      dv[i] = DA_W'($signed(s_tdata[IW*i +: IW]))
            - DA_W'($signed(s_tdata[IW*(3+i) +: IW]));
      am_n[i] = av[i][DA_W-1] ? DA_W'(-av[i]) : DA_W'(av[i]);
      dm_n[i] = dv[i][DA_W-1] ? DA_W'(-dv[i]) : DA_W'(dv[i]);
      fs_n[i] = s_tdata[IW*(9+i) + IW-1];
      fm_n[i] = fs_n[i] ? IW'(-s_tdata[IW*(9+i) +: IW]) : s_tdata[IW*(9+i) +: IW];
    end
    for (int i = 0; i < 3; i++) begin
      ps1_n[i] = av[(i+1)%3][DA_W-1] ^ dv[(i+2)%3][DA_W-1];
      ps2_n[i] = dv[(i+1)%3][DA_W-1] ^ av[(i+2)%3][DA_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        am[i] <= am_n[i];
        dm[i] <= dm_n[i];
        f_m1[IW*i +: IW] <= fm_n[i];
        f_s1[i] <= fs_n[i];
      end
      ps1 <= ps1_n;
      ps2 <= ps2_n;
    end
  end

  // First multiply: cross-product terms and axis squares
  logic [PR_W-1:0] p1 [3];
  logic [PR_W-1:0] p2 [3];
  logic [PR_W-1:0] sq [3];
  logic [5:0]      psg;

  for (genvar i = 0; i < 3; i++) begin : g_m1
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    fmaa_mul #(.WA(DA_W), .WB(DA_W)) u_p1 (
      .clk(clk), .en(en), .a(am[J]), .b(dm[K]), .p(p1[i]));
    fmaa_mul #(.WA(DA_W), .WB(DA_W)) u_p2 (
      .clk(clk), .en(en), .a(dm[J]), .b(am[K]), .p(p2[i]));
    fmaa_mul #(.WA(DA_W), .WB(DA_W)) u_sq (
      .clk(clk), .en(en), .a(am[i]), .b(am[i]), .p(sq[i]));
  end

  fmaa_dly #(.W(6), .D(L_M1)) u_psg (
    .clk(clk), .en(en), .din({ps2, ps1}), .dout(psg));

  logic [3*IW-1:0] f_m6;
  logic [2:0]      f_s6;
  fmaa_dly #(.W(3*IW+3), .D(D_F)) u_fdly (
    .clk(clk), .en(en), .din({f_s1, f_m1}), .dout({f_s6, f_m6}));

  // Stage C1: signed cross product and axis norm square
  logic signed [C_W-1:0] cv [3];
  logic [AS_W-1:0]       asum;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cv[i] <= (psg[i]   ? -$signed(C_W'(p1[i])) : $signed(C_W'(p1[i])))
               - (psg[3+i] ? -$signed(C_W'(p2[i])) : $signed(C_W'(p2[i])));
      end
      asum <= sq[0] + sq[1] + sq[2];
    end
  end

  // Stage C2: cross-product magnitudes and signs
  logic [CM_W-1:0] cm [3];
  logic [2:0]      cs;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cm[i] <= CM_W'(cv[i][C_W-1] ? -cv[i] : cv[i]);
        cs[i] <= cv[i][C_W-1];
      end
    end
  end

  // Second multiply: |c|^2 and |F||c|
  logic [CS_W-1:0] cc  [3];
  logic [FC_W-1:0] fc  [3];
  logic [FC_W-1:0] fcd [3];
  logic [2:0]      fcs;

  for (genvar i = 0; i < 3; i++) begin : g_m2
    fmaa_mul #(.WA(CM_W), .WB(CM_W)) u_cc (
      .clk(clk), .en(en), .a(cm[i]), .b(cm[i]), .p(cc[i]));
    fmaa_mul #(.WA(IW), .WB(CM_W)) u_fc (
      .clk(clk), .en(en), .a(f_m6[IW*i +: IW]), .b(cm[i]), .p(fc[i]));
    fmaa_dly #(.W(FC_W), .D(D_FC)) u_fcd (
      .clk(clk), .en(en), .din(fc[i]), .dout(fcd[i]));
  end

  fmaa_dly #(.W(3), .D(L_CC)) u_fcs (
    .clk(clk), .en(en), .din(f_s6 ^ cs), .dout(fcs));

  // Stage P1: norm square of c and force dot product
  logic [CS_W-1:0]      csum;
  logic signed [P_W-1:0] psum;

  always_ff @(posedge clk) begin
    if (en) begin
      csum <= cc[0] + cc[1] + cc[2];
      psum <= (fcs[0] ? -$signed(P_W'(fcd[0])) : $signed(P_W'(fcd[0])))
            + (fcs[1] ? -$signed(P_W'(fcd[1])) : $signed(P_W'(fcd[1])))
            + (fcs[2] ? -$signed(P_W'(fcd[2])) : $signed(P_W'(fcd[2])));
    end
  end

  // Stage P2: dot product magnitude and sign
  logic [PM_W-1:0] pm;
  logic            pneg;

  always_ff @(posedge clk) begin
    if (en) begin
      pneg <= psum[P_W-1];
      pm   <= PM_W'(psum[P_W-1] ? -psum : psum);
    end
  end

  // Square roots of both norm squares
  logic [NC_W-1:0] nc;
  logic [NA_W-1:0] na, na_d;
  logic [PM_W-1:0] pm_d;
  logic            pneg_d;

  fmaa_sqrt #(.WN(CS_W)) u_sqc (.clk(clk), .en(en), .n(csum), .root(nc));
  fmaa_sqrt #(.WN(AS_W)) u_sqa (.clk(clk), .en(en), .n(asum), .root(na));

  fmaa_dly #(.W(NA_W), .D(D_NA)) u_nad (
    .clk(clk), .en(en), .din(na), .dout(na_d));
  fmaa_dly #(.W(PM_W+1), .D(L_SQC)) u_pmd (
    .clk(clk), .en(en), .din({pneg, pm}), .dout({pneg_d, pm_d}));

  // Stage Q1: divisors with epsilon, zero-divisor flags
  logic [NC_W-1:0]   nc_q;
  logic [DEN1_W-1:0] den1;
  logic [NCE_W-1:0]  nce;
  logic [DEN1_W-1:0] den1_n;
  logic [NCE_W-1:0]  nce_n;
  logic              zd, zm;

  assign den1_n = DEN1_W'(na_d) + DEN1_W'(epsilon);
  assign nce_n  = NCE_W'(nc) + (NCE_W'(epsilon) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      nc_q <= nc;
      den1 <= den1_n;
      nce  <= nce_n;
      zd   <= (den1_n == '0);
      zm   <= (den1_n == '0) || (nce_n == '0);
    end
  end

  // Third multiply: moment numerator and denominator
  logic [MN_W-1:0] mnum;
  logic [MD_W-1:0] mden, mden_d;

  fmaa_mul #(.WA(NC_W), .WB(PM_W)) u_mn (
    .clk(clk), .en(en), .a(nc_q), .b(pm_d), .p(mnum));
  fmaa_mul #(.WA(DEN1_W), .WB(NCE_W)) u_md (
    .clk(clk), .en(en), .a(den1), .b(nce), .p(mden));
  fmaa_dly #(.W(MD_W), .D(D_MD)) u_mdd (
    .clk(clk), .en(en), .din(mden), .dout(mden_d));

  // Quotients
  logic [MW-1:0] mq;
  logic          movf;
  logic [DW-1:0] dq, dq_d;
  logic          dovf, dovf_d;
  logic          neg_t, zm_t, zd_t;

  fmaa_div #(.WN(MN_W), .WD(MD_W), .WQ(MW)) u_divm (
    .clk(clk), .en(en), .n(mnum), .d(mden_d), .q(mq), .ovf(movf));
  fmaa_div #(.WN(NC_W), .WD(DEN1_W), .WQ(DW)) u_divd (
    .clk(clk), .en(en), .n(nc_q), .d(den1), .q(dq), .ovf(dovf));

  fmaa_dly #(.W(DW+1), .D(D_DST)) u_dstd (
    .clk(clk), .en(en), .din({dovf, dq}), .dout({dovf_d, dq_d}));
  fmaa_dly #(.W(3), .D(D_FLG)) u_flg (
    .clk(clk), .en(en), .din({pneg_d, zm, zd}), .dout({neg_t, zm_t, zd_t}));

  // Saturate and sign the results
  logic [MW-1:0] mom;
  logic [DW-1:0] dst;

  always_comb begin
    if (zm_t) begin
      mom = '0;
    end else if (movf) begin
      mom = neg_t ? fmaa_pkg::MOM_MIN : fmaa_pkg::MOM_MAX;
    end else if (neg_t) begin
      mom = (mq > fmaa_pkg::MOM_MIN) ? fmaa_pkg::MOM_MIN : MW'(-mq);
    end else begin
      mom = mq[MW-1] ? fmaa_pkg::MOM_MAX : mq;
    end
    if (zd_t) begin
      dst = '0;
    end else if (dovf_d) begin
      dst = '1;
    end else begin
      dst = dq_d;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_tready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v  <= vld[L_TOT-1];
      end
    end else if (vld[L_TOT-1] && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_tready) begin
      out_d <= skid_v ? skid_d : {dst, mom};
    end else if (en) begin
      skid_d <= {dst, mom};
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_d;

endmodule
